// ----- design/msog_pkg.sv -----
`timescale 1ns / 1ps

package msog_pkg;

    // request kinds
    typedef enum logic {
        REQ_POLL = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOW_VOLTAGE_LIMIT   = 3'd0,
        CFG_LOCKED_POLL_LIMIT   = 3'd1,
        CFG_OVERLOAD_POLL_LIMIT = 3'd2,
        CFG_NORMAL_RPM_FLOOR    = 3'd3,
        CFG_FAST_RPM_FLOOR      = 3'd4,
        CFG_BAND_SPLIT          = 3'd5,
        CFG_COOLDOWN_TICKS      = 3'd6
    } cfg_addr_t;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    // register reset values
    localparam logic [9:0]  LowVoltageLimitRst   = 10'd81;
    localparam logic [15:0] LockedPollLimitRst   = 16'd80;
    localparam logic [15:0] OverloadPollLimitRst = 16'd160;
    localparam logic [14:0] NormalRpmFloorRst    = 15'd20;
    localparam logic [14:0] FastRpmFloorRst      = 15'd50;
    localparam logic [6:0]  BandSplitRst         = 7'd75;
    localparam logic [15:0] CooldownTicksRst     = 16'd3000;

    localparam logic [15:0] CountMax = 16'hFFFF;

    typedef struct packed {
        req_type_t          req_type;
        logic [9:0]         voltage;
        logic signed [7:0]  speed_cmd;
        logic signed [7:0]  steer_cmd;
        logic               power_on;
        logic signed [15:0] wheel_rpm_a;
        logic signed [15:0] wheel_rpm_b;
        logic signed [15:0] wheel_rpm_c;
        logic signed [15:0] wheel_rpm_d;
    } in_item_t;

    typedef struct packed {
        logic        stop_motors;
        logic        protecting;
        logic        cooling;
        logic        low_voltage;
        logic [15:0] locked_events;
        logic [15:0] overload_events;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  low_voltage_limit;
        logic [15:0] locked_poll_limit;
        logic [15:0] overload_poll_limit;
        logic [14:0] normal_rpm_floor;
        logic [14:0] fast_rpm_floor;
        logic [6:0]  band_split;
        logic [15:0] cooldown_ticks;
    } cfg_t;

    typedef struct packed {
        logic [15:0] persist_count;
        logic        protect_hold;
        logic        trip_latched;
        logic [15:0] cooldown_left;
        logic [15:0] locked_total;
        logic [15:0] overload_total;
    } guard_state_t;

    // magnitude of a signed command, one bit wider
    function automatic logic [8:0] abs_cmd(input logic signed [7:0] v);
        logic signed [8:0] x;
        x = {v[7], v};
        return x[8] ? 9'(-x) : 9'(x);
    endfunction

    // magnitude of a signed wheel speed, one bit wider
    function automatic logic [16:0] abs_rpm(input logic signed [15:0] v);
        logic signed [16:0] x;
        x = {v[15], v};
        return x[16] ? 17'(-x) : 17'(x);
    endfunction

    // saturating 16-bit increment
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == CountMax) ? v : v + 16'd1;
    endfunction

endpackage

// ----- design/motor_stall_overload_guard.sv -----
`timescale 1ns / 1ps

// Stall and overload guard for a four-wheel drive.
// in channel: in_valid / in_stall / in_data carry one poll or one time tick per beat.
// out channel: out_valid / out_stall / out_data return exactly one result per input beat,
// in order.
// cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data write one register per beat;
// cfg_ready is always high. Write only while no item is in flight.
// Path: a taken beat sits in the input register and is evaluated; its result lands in the
// output register once that register is free, which raises out_valid.
// Throughput: one item per cycle while out_stall is low; the guard state updates in a
// single pass between the input register and the output register.
// Stalls: while out_stall holds a waiting result, one more item is still taken into the
// input register; in_stall rises only once both registers are full.
// Reset: rst_n clears the valid bits of both pipeline registers, the counters, flags and
// event totals, and loads the register defaults.

module motor_stall_overload_guard
    import msog_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    cfg_t         cfg;
    guard_state_t state_reg;
    guard_state_t state_next;
    out_item_t    result;
    in_item_t     s1_item_reg;
    logic         s1_valid_reg;
    out_item_t    out_item_reg;
    logic         out_valid_reg;
    logic         in_take;
    logic         s1_move;

    // configuration registers
    assign cfg_ready = 1'b1;

    msog_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // handshake control
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_move)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
    end

    // single-pass evaluation
    msog_eval u_eval (
        .item       (s1_item_reg),
        .state_cur  (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    // guard state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_move)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= s1_move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.trip_latched == (state_reg.cooldown_left != 16'd0))
        else $error("trip latch and cooldown disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.low_voltage |-> out_item_reg.stop_motors)
        else $error("low voltage result without stop");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.locked_total >= $past(state_reg.locked_total) &&
        state_reg.overload_total >= $past(state_reg.overload_total))
        else $error("event total decreased");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with free pipeline room");

endmodule

// ----- design/msog_cfg.sv -----
`timescale 1ns / 1ps

module msog_cfg
    import msog_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CfgIndexW-1:0] wr_index,
    input  logic [CfgDataW-1:0]  wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // register file, one write per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_voltage_limit   <= LowVoltageLimitRst;
            cfg_reg.locked_poll_limit   <= LockedPollLimitRst;
            cfg_reg.overload_poll_limit <= OverloadPollLimitRst;
            cfg_reg.normal_rpm_floor    <= NormalRpmFloorRst;
            cfg_reg.fast_rpm_floor      <= FastRpmFloorRst;
            cfg_reg.band_split          <= BandSplitRst;
            cfg_reg.cooldown_ticks      <= CooldownTicksRst;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_LOW_VOLTAGE_LIMIT:   cfg_reg.low_voltage_limit   <= wr_data[9:0];
                CFG_LOCKED_POLL_LIMIT:   cfg_reg.locked_poll_limit   <= wr_data[15:0];
                CFG_OVERLOAD_POLL_LIMIT: cfg_reg.overload_poll_limit <= wr_data[15:0];
                CFG_NORMAL_RPM_FLOOR:    cfg_reg.normal_rpm_floor    <= wr_data[14:0];
                CFG_FAST_RPM_FLOOR:      cfg_reg.fast_rpm_floor      <= wr_data[14:0];
                CFG_BAND_SPLIT:          cfg_reg.band_split          <= wr_data[6:0];
                CFG_COOLDOWN_TICKS:      cfg_reg.cooldown_ticks      <= wr_data[15:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/msog_eval.sv -----
`timescale 1ns / 1ps

module msog_eval
    import msog_pkg::*;
(
    input  in_item_t     item,
    input  guard_state_t state_cur,
    input  cfg_t         cfg,
    output guard_state_t state_next,
    output out_item_t    result
);

    logic [8:0]  as_mag;
    logic [8:0]  at_mag;
    logic [8:0]  split;
    logic [16:0] rpm_mag [4];
    logic [3:0]  rpm_zero;
    logic [3:0]  rpm_slow_n;
    logic [3:0]  rpm_slow_f;
    logic        is_poll;
    logic        lowv;
    logic        active;
    logic        idle_clear;
    logic        normal_band;
    logic        fast_band;
    logic        adv0, adv1, adv2;
    logic        t0, t1, t2;
    logic        trip;
    logic        new_event;
    logic [15:0] p1, p2, p3;
    logic [15:0] cd_load;

    // per-wheel compares
    always_comb
    begin
        rpm_mag[0] = abs_rpm(item.wheel_rpm_a);
        rpm_mag[1] = abs_rpm(item.wheel_rpm_b);
        rpm_mag[2] = abs_rpm(item.wheel_rpm_c);
        rpm_mag[3] = abs_rpm(item.wheel_rpm_d);
        for (int i = 0; i < 4; i++)
        begin
            rpm_zero[i]   = (rpm_mag[i] == 17'd0);
            rpm_slow_n[i] = (rpm_mag[i] <= {2'b00, cfg.normal_rpm_floor});
            rpm_slow_f[i] = (rpm_mag[i] <= {2'b00, cfg.fast_rpm_floor});
        end
    end

    // command bands
    assign as_mag = abs_cmd(item.speed_cmd);
    assign at_mag = abs_cmd(item.steer_cmd);
    assign split  = {2'b00, cfg.band_split};

    assign normal_band = ((as_mag != 9'd0) && (as_mag <= split)) ||
                         ((at_mag != 9'd0) && (at_mag <= split));
    assign fast_band   = ((as_mag != 9'd0) && (as_mag > split)) ||
                         ((at_mag != 9'd0) && (at_mag > split));

    // poll classification
    assign is_poll    = (item.req_type == REQ_POLL);
    assign lowv       = is_poll && (item.voltage <= cfg.low_voltage_limit);
    assign active     = is_poll && !lowv && item.power_on &&
                        ((as_mag != 9'd0) || (at_mag != 9'd0));
    assign idle_clear = is_poll && !lowv && !active && !(|rpm_zero);

    // three checks sharing the persistence counter; a trip ends the chain
    assign adv0 = active && (|rpm_zero);
    assign p1   = adv0 ? sat_inc(state_cur.persist_count) : state_cur.persist_count;
    assign t0   = adv0 && (p1 >= cfg.locked_poll_limit);

    assign adv1 = active && !t0 && normal_band && (|rpm_slow_n);
    assign p2   = adv1 ? sat_inc(p1) : p1;
    assign t1   = adv1 && (p2 >= cfg.overload_poll_limit);

    assign adv2 = active && !t0 && !t1 && fast_band && (|rpm_slow_f);
    assign p3   = adv2 ? sat_inc(p2) : p2;
    assign t2   = adv2 && (p3 >= cfg.overload_poll_limit);

    assign trip      = t0 || t1 || t2;
    assign new_event = trip && !state_cur.trip_latched;
    assign cd_load   = (cfg.cooldown_ticks == 16'd0) ? 16'd1 : cfg.cooldown_ticks;

    // next state
    always_comb
    begin
        state_next = state_cur;
        if (!is_poll)
        begin
            if (state_cur.cooldown_left != 16'd0)
            begin
                state_next.cooldown_left = state_cur.cooldown_left - 16'd1;
                if (state_cur.cooldown_left == 16'd1)
                begin
                    state_next.persist_count = 16'd0;
                    state_next.protect_hold  = 1'b0;
                    state_next.trip_latched  = 1'b0;
                end
            end
        end
        else if (active)
        begin
            state_next.persist_count = p3;
            if (trip)
            begin
                state_next.protect_hold = 1'b1;
                state_next.trip_latched = 1'b1;
            end
            if (new_event)
            begin
                state_next.cooldown_left = cd_load;
                if (t0)
                begin
                    state_next.locked_total = sat_inc(state_cur.locked_total);
                end
                else
                begin
                    state_next.overload_total = sat_inc(state_cur.overload_total);
                end
            end
        end
        else if (idle_clear)
        begin
            state_next.persist_count = 16'd0;
            state_next.protect_hold  = 1'b0;
        end
    end

    // result fields
    assign result.stop_motors     = lowv || trip;
    assign result.protecting      = state_next.protect_hold;
    assign result.cooling         = state_next.trip_latched;
    assign result.low_voltage     = lowv;
    assign result.locked_events   = state_next.locked_total;
    assign result.overload_events = state_next.overload_total;

endmodule

// ----- sim/tb_motor_stall_overload_guard.sv -----
`timescale 1ns / 1ps

module tb_motor_stall_overload_guard;
    import msog_pkg::*;

    localparam int IdleMax       = 14;
    localparam int WatchdogLimit = 2000;
    localparam int TailCycles    = 10;
    localparam int PrintCap      = 100;

    // guard predictor and queue of expected result beats
    class guard_scoreboard;
        cfg_t        regs;
        logic [15:0] persist;
        bit          protect_on;
        bit          latched;
        logic [15:0] cool_left;
        logic [15:0] locked_total;
        logic [15:0] overload_total;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            regs.low_voltage_limit   = LowVoltageLimitRst;
            regs.locked_poll_limit   = LockedPollLimitRst;
            regs.overload_poll_limit = OverloadPollLimitRst;
            regs.normal_rpm_floor    = NormalRpmFloorRst;
            regs.fast_rpm_floor      = FastRpmFloorRst;
            regs.band_split          = BandSplitRst;
            regs.cooldown_ticks      = CooldownTicksRst;
            persist        = '0;
            protect_on     = 1'b0;
            latched        = 1'b0;
            cool_left      = '0;
            locked_total   = '0;
            overload_total = '0;
            errors         = 0;
        endfunction

        // register write, masked to the register width
        function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
            case (cfg_addr_t'(idx))
                CFG_LOW_VOLTAGE_LIMIT:   regs.low_voltage_limit   = val[9:0];
                CFG_LOCKED_POLL_LIMIT:   regs.locked_poll_limit   = val;
                CFG_OVERLOAD_POLL_LIMIT: regs.overload_poll_limit = val;
                CFG_NORMAL_RPM_FLOOR:    regs.normal_rpm_floor    = val[14:0];
                CFG_FAST_RPM_FLOOR:      regs.fast_rpm_floor      = val[14:0];
                CFG_BAND_SPLIT:          regs.band_split          = val[6:0];
                CFG_COOLDOWN_TICKS:      regs.cooldown_ticks      = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        // advance persistence, trip when the limit is reached
        function bit count_check(logic [15:0] limit, bit locked_kind);
            persist = bump(persist);
            if (persist < limit)
                return 1'b0;
            protect_on = 1'b1;
            if (!latched)
            begin
                if (locked_kind)
                    locked_total = bump(locked_total);
                else
                    overload_total = bump(overload_total);
                latched   = 1'b1;
                cool_left = (regs.cooldown_ticks == 16'd0) ? 16'd1 : regs.cooldown_ticks;
            end
            return 1'b1;
        endfunction

        // accepted input beat: update the guard and queue its result
        function void note_input(in_item_t it);
            out_item_t exp_res;
            int        spd;
            int        str;
            int        mag_s;
            int        mag_t;
            int        split_at;
            int        rpm[4];
            bit        stopped;
            bit        lowv;
            bit        hit;
            stopped = 1'b0;
            lowv    = 1'b0;
            if (it.req_type == REQ_TICK)
            begin
                if (cool_left != 16'd0)
                begin
                    cool_left = cool_left - 16'd1;
                    if (cool_left == 16'd0)
                    begin
                        persist    = '0;
                        protect_on = 1'b0;
                        latched    = 1'b0;
                    end
                end
            end
            else
            begin
                spd      = $signed(it.speed_cmd);
                str      = $signed(it.steer_cmd);
                rpm[0]   = $signed(it.wheel_rpm_a);
                rpm[1]   = $signed(it.wheel_rpm_b);
                rpm[2]   = $signed(it.wheel_rpm_c);
                rpm[3]   = $signed(it.wheel_rpm_d);
                split_at = int'(regs.band_split);
                if (int'(it.voltage) <= int'(regs.low_voltage_limit))
                begin
                    lowv    = 1'b1;
                    stopped = 1'b1;
                end
                else if ((spd != 0 || str != 0) && it.power_on)
                begin
                    mag_s = (spd < 0) ? -spd : spd;
                    mag_t = (str < 0) ? -str : str;

                    // locked rotor: any wheel standing still
                    hit = 1'b0;
                    for (int i = 0; i < 4; i++)
                        if (rpm[i] == 0)
                            hit = 1'b1;
                    if (hit)
                    begin
                        if (count_check(regs.locked_poll_limit, 1'b1))
                        begin
                            stopped = 1'b1;
                            mag_s   = 0;
                            mag_t   = 0;
                        end
                    end

                    // normal band overload
                    if ((mag_s != 0 && mag_s <= split_at) || (mag_t != 0 && mag_t <= split_at))
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < 4; i++)
                            if (((rpm[i] < 0) ? -rpm[i] : rpm[i]) <= int'(regs.normal_rpm_floor))
                                hit = 1'b1;
                        if (hit)
                        begin
                            if (count_check(regs.overload_poll_limit, 1'b0))
                            begin
                                stopped = 1'b1;
                                mag_s   = 0;
                                mag_t   = 0;
                            end
                        end
                    end

                    // fast band overload
                    if ((mag_s != 0 && mag_s > split_at) || (mag_t != 0 && mag_t > split_at))
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < 4; i++)
                            if (((rpm[i] < 0) ? -rpm[i] : rpm[i]) <= int'(regs.fast_rpm_floor))
                                hit = 1'b1;
                        if (hit)
                        begin
                            if (count_check(regs.overload_poll_limit, 1'b0))
                                stopped = 1'b1;
                        end
                    end
                end
                else
                begin
                    // idle drive with every wheel turning
                    if (rpm[0] != 0 && rpm[1] != 0 && rpm[2] != 0 && rpm[3] != 0)
                    begin
                        persist    = '0;
                        protect_on = 1'b0;
                    end
                end
            end
            exp_res.stop_motors     = stopped;
            exp_res.protecting      = protect_on;
            exp_res.cooling         = latched;
            exp_res.low_voltage     = lowv;
            exp_res.locked_events   = locked_total;
            exp_res.overload_events = overload_total;
            expected_q.push_back(exp_res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PrintCap)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        // accepted result beat against the oldest expectation
        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report("result beat with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            check_field("stop_motors", 16'(got.stop_motors), 16'(want.stop_motors));
            check_field("protecting", 16'(got.protecting), 16'(want.protecting));
            check_field("cooling", 16'(got.cooling), 16'(want.cooling));
            check_field("low_voltage", 16'(got.low_voltage), 16'(want.low_voltage));
            check_field("locked_events", got.locked_events, want.locked_events);
            check_field("overload_events", got.overload_events, want.overload_events);
        endtask

        task check_leftovers();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_q.size()));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    guard_scoreboard sb = new();
    bit              idling = 1'b1;
    int              quiet_cycles = 0;

    motor_stall_overload_guard i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (in_valid && !in_stall)
                sb.note_input(in_data);
            if ((cfg_valid && cfg_ready) || (out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side stall, redrawn after each taken beat
    initial
    begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                hold = idling ? $urandom_range(0, IdleMax) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // send one input beat after a random gap, valid stays high when there is none
    task automatic push_item(input in_item_t it);
        int gap;
        gap = idling ? $urandom_range(0, IdleMax) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // hold the input side until every expected result has come
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // write all seven registers back to back
    task automatic load_config(input cfg_t c);
        logic [CfgDataW-1:0] val;
        for (int i = 0; i < 7; i++)
        begin
            case (cfg_addr_t'(i))
                CFG_LOW_VOLTAGE_LIMIT:   val = 16'(c.low_voltage_limit);
                CFG_LOCKED_POLL_LIMIT:   val = c.locked_poll_limit;
                CFG_OVERLOAD_POLL_LIMIT: val = c.overload_poll_limit;
                CFG_NORMAL_RPM_FLOOR:    val = 16'(c.normal_rpm_floor);
                CFG_FAST_RPM_FLOOR:      val = 16'(c.fast_rpm_floor);
                CFG_BAND_SPLIT:          val = 16'(c.band_split);
                default:                 val = c.cooldown_ticks;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= cfg_addr_t'(i);
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t make_config(int lvl, int lck, int ovl, int nfl, int ffl,
                                         int spl, int cdn);
        cfg_t c;
        c.low_voltage_limit   = 10'(lvl);
        c.locked_poll_limit   = 16'(lck);
        c.overload_poll_limit = 16'(ovl);
        c.normal_rpm_floor    = 15'(nfl);
        c.fast_rpm_floor      = 15'(ffl);
        c.band_split          = 7'(spl);
        c.cooldown_ticks      = 16'(cdn);
        return c;
    endfunction

    function automatic in_item_t make_poll(int volt, int spd, int str, bit pwr,
                                           int a, int b, int c, int d);
        in_item_t it;
        it.req_type    = REQ_POLL;
        it.voltage     = 10'(volt);
        it.speed_cmd   = 8'(spd);
        it.steer_cmd   = 8'(str);
        it.power_on    = pwr;
        it.wheel_rpm_a = 16'(a);
        it.wheel_rpm_b = 16'(b);
        it.wheel_rpm_c = 16'(c);
        it.wheel_rpm_d = 16'(d);
        return it;
    endfunction

    function automatic in_item_t noise_item();
        logic [95:0] r;
        in_item_t    it;
        r  = {$urandom(), $urandom(), $urandom()};
        it = r[$bits(in_item_t)-1:0];
        return it;
    endfunction

    // tick with random payload in the unused fields
    function automatic in_item_t make_tick();
        in_item_t it;
        it = noise_item();
        it.req_type = REQ_TICK;
        return it;
    endfunction

    function automatic logic [15:0] pick_value(int width, int typical_max);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'((1 << width) - 1);
        if (r == 2)
            return 16'($urandom_range(0, (1 << width) - 1));
        return 16'($urandom_range(0, typical_max));
    endfunction

    // mostly small limits and short cooldowns so trips and expiries happen often
    function automatic cfg_t random_config();
        cfg_t c;
        c.low_voltage_limit   = 10'(pick_value(10, 120));
        c.locked_poll_limit   = pick_value(16, 12);
        c.overload_poll_limit = pick_value(16, 12);
        c.normal_rpm_floor    = 15'(pick_value(15, 100));
        c.fast_rpm_floor      = 15'(pick_value(15, 100));
        c.band_split          = 7'(pick_value(7, 127));
        c.cooldown_ticks      = pick_value(16, 20);
        return c;
    endfunction

    function automatic logic [7:0] random_cmd();
        return ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom());
    endfunction

    // wheel speed: often zero, often near the floor, otherwise anything
    function automatic logic [15:0] random_rpm(int fl);
        int r;
        int top;
        int v;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 16'd0;
        if (r < 65)
        begin
            top = (fl + 10 > 32767) ? 32767 : fl + 10;
            v   = $urandom_range(1, top);
            return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
        end
        return 16'($urandom());
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       sel;
        int       lvl;
        int       fl;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return noise_item();
        if (sel < 28)
            return make_tick();
        lvl = int'(sb.regs.low_voltage_limit);
        it.req_type = REQ_POLL;
        if ($urandom_range(0, 6) == 0 || lvl >= 1023)
            it.voltage = 10'($urandom_range(0, 1023));
        else
            it.voltage = 10'($urandom_range(lvl + 1, 1023));
        it.speed_cmd = random_cmd();
        it.steer_cmd = random_cmd();
        it.power_on  = ($urandom_range(0, 9) != 0);
        fl = $urandom_range(0, 1) ? int'(sb.regs.normal_rpm_floor) : int'(sb.regs.fast_rpm_floor);
        it.wheel_rpm_a = random_rpm(fl);
        it.wheel_rpm_b = random_rpm(fl);
        it.wheel_rpm_c = random_rpm(fl);
        it.wheel_rpm_d = random_rpm(fl);
        return it;
    endfunction

    // stimulus
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LOW_VOLTAGE_LIMIT;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: tick without cooldown, low voltage, an active poll with no trip, idle paths
        push_item(make_tick());
        push_item(make_poll(0, 10, 10, 1'b1, 100, 100, 100, 100));
        push_item(make_poll(81, 0, 0, 1'b0, 0, 0, 0, 0));
        push_item(make_poll(1023, -128, 127, 1'b1, 32767, -32768, 32767, -32768));
        push_item(make_poll(500, 40, -40, 1'b0, 1, -1, 5, 7));
        push_item(make_poll(500, 0, 0, 1'b1, 0, 9, 9, 9));
        wait_all_results();

        // zero low-voltage and locked limits, overload limit of one, zero cooldown
        load_config(make_config(0, 0, 1, 0, 32767, 0, 0));
        push_item(make_poll(1, 5, 0, 1'b1, 0, 100, 100, 100));
        push_item(make_poll(1, 5, 0, 1'b1, 0, 100, 100, 100));
        push_item(make_tick());
        push_item(make_poll(1, 5, 0, 1'b1, 100, 100, 100, 100));
        push_item(make_tick());
        push_item(make_poll(1, 1, 0, 1'b1, -32768, -32768, -32768, -32768));
        wait_all_results();

        // all registers at their maximum
        idling = 1'b1;
        load_config(make_config(1023, 65535, 65535, 32767, 32767, 127, 65535));
        push_item(make_poll(1023, 127, 127, 1'b1, 0, 0, 0, 0));
        push_item(make_tick());
        wait_all_results();

        // random phases, one without idling
        for (int ph = 0; ph < 4; ph++)
        begin
            load_config(random_config());
            idling = (ph != 2);
            for (int n = 0; n < 250; n++)
            begin
                push_item(random_item());
                if ($urandom_range(0, 59) == 0)
                    wait_all_results();
            end
            wait_all_results();
        end

        repeat (TailCycles) @(posedge clk);
        sb.check_leftovers();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- motor_stall_overload_guard.f -----
design/msog_pkg.sv
design/msog_cfg.sv
design/msog_eval.sv
design/motor_stall_overload_guard.sv
sim/tb_motor_stall_overload_guard.sv
